[design/b64_pkg.sv]
// ---------------------------------------------------------------------------
// b64_pkg: shared types and helpers for the base64 encoder
// Beat types for both channels, the group record passed from the byte
// collector to the character serialiser, and the alphabet lookup.
// ---------------------------------------------------------------------------
`default_nettype none

package b64_pkg;

    localparam logic [6:0] PAD_CHAR = 7'd61;
    localparam logic [5:0] SIX_BITS = 6'h3F;

    // Number of real bytes in a group.
    localparam logic [1:0] GRP_ONE  = 2'd1;
    localparam logic [1:0] GRP_TWO  = 2'd2;
    localparam logic [1:0] GRP_FULL = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } in_beat_t;

    typedef struct packed {
        logic [6:0] out_char;
        logic       last_char;
    } out_beat_t;

    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [1:0] nbytes;
        logic       last;
    } group_t;

    // Maps a sextet onto A-Z a-z 0-9 + /.
    function automatic logic [6:0] sextet_char(input logic [5:0] v);
        logic [6:0] v7;
        v7 = {1'b0, v & SIX_BITS};
        if (v7 < 7'd26)
        begin
            return 7'd65 + v7;
        end
        else if (v7 < 7'd52)
        begin
            return 7'd71 + v7;
        end
        else if (v7 < 7'd62)
        begin
            return v7 - 7'd4;
        end
        else if (v7 == 7'd62)
        begin
            return 7'd43;
        end
        else
        begin
            return 7'd47;
        end
    endfunction

endpackage

`default_nettype wire

[design/b64_front.sv]
// ---------------------------------------------------------------------------
// b64_front: byte collector
// Accepts message bytes, holds up to two of them and hands a complete or
// closing group of bytes to the group queue.
// ---------------------------------------------------------------------------
`default_nettype none

module b64_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  b64_pkg::in_beat_t      in_data,
    output logic                   push_valid,
    input  wire logic              push_ready,
    output b64_pkg::group_t        push_data
);
    import b64_pkg::*;

    logic [1:0] count_reg, count_next;
    logic [7:0] p0_reg, p0_next;
    logic [7:0] p1_reg, p1_next;
    logic       accept;

    // Every beat may close a group, so the queue must have room.
    assign in_ready = push_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        count_next = count_reg;
        p0_next    = p0_reg;
        p1_next    = p1_reg;
        push_valid = 1'b0;
        push_data  = '0;
        case (count_reg)
            2'd0:
            begin
                push_data = '{b0: in_data.data_byte, b1: 8'd0, b2: 8'd0,
                              nbytes: GRP_ONE, last: 1'b1};
                push_valid = in_valid && in_data.end_of_message;
                if (accept && !in_data.end_of_message)
                begin
                    p0_next    = in_data.data_byte;
                    count_next = 2'd1;
                end
            end
            2'd1:
            begin
                push_data = '{b0: p0_reg, b1: in_data.data_byte, b2: 8'd0,
                              nbytes: GRP_TWO, last: 1'b1};
                push_valid = in_valid && in_data.end_of_message;
                if (accept)
                begin
                    if (in_data.end_of_message)
                    begin
                        count_next = 2'd0;
                    end
                    else
                    begin
                        p1_next    = in_data.data_byte;
                        count_next = 2'd2;
                    end
                end
            end
            2'd2:
            begin
                push_data = '{b0: p0_reg, b1: p1_reg, b2: in_data.data_byte,
                              nbytes: GRP_FULL, last: in_data.end_of_message};
                push_valid = in_valid;
                if (accept)
                begin
                    count_next = 2'd0;
                end
            end
            default:
            begin
                count_next = 2'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p0_reg <= p0_next;
        p1_reg <= p1_next;
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("byte collector holds more than two bytes");

endmodule

`default_nettype wire

[design/b64_queue.sv]
// ---------------------------------------------------------------------------
// b64_queue: two-entry group queue
// Decouples the byte collector from the character serialiser so that
// either side can stall without holding up the other.
// ---------------------------------------------------------------------------
`default_nettype none

module b64_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push_valid,
    output logic                   push_ready,
    input  b64_pkg::group_t        push_data,
    output logic                   pop_valid,
    input  wire logic              pop_ready,
    output b64_pkg::group_t        pop_data
);
    import b64_pkg::*;

    group_t     mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = mem[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("group queue overflow");

    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("group queue pointers disagree with fill count");

endmodule

`default_nettype wire

[design/b64_back.sv]
// ---------------------------------------------------------------------------
// b64_back: character serialiser
// Takes one group at a time from the queue and sends its four characters,
// one per beat, through a registered output stage.
// ---------------------------------------------------------------------------
`default_nettype none

module b64_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              pop_valid,
    output logic                   pop_ready,
    input  b64_pkg::group_t        pop_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output b64_pkg::out_beat_t     out_data
);
    import b64_pkg::*;

    group_t     grp_reg, grp_next;
    logic       grp_valid_reg, grp_valid_next;
    logic [1:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    out_beat_t  out_reg, out_next;
    logic       load;
    logic [5:0] sextet;
    logic [6:0] code;

    // The output register can take a new character when empty or draining.
    assign load = grp_valid_reg && (!out_valid_reg || out_ready);

    // Fetch the next group while the current one sends its final character.
    assign pop_ready = !grp_valid_reg || (load && idx_reg == 2'd3);

    always_comb
    begin
        case (idx_reg)
            2'd0:    sextet = grp_reg.b0[7:2];
            2'd1:    sextet = {grp_reg.b0[1:0], grp_reg.b1[7:4]};
            2'd2:    sextet = {grp_reg.b1[3:0], grp_reg.b2[7:6]};
            default: sextet = grp_reg.b2[5:0];
        endcase

        code = sextet_char(sextet);
        if ((idx_reg == 2'd2 && grp_reg.nbytes == GRP_ONE) ||
            (idx_reg == 2'd3 && grp_reg.nbytes != GRP_FULL))
        begin
            code = PAD_CHAR;
        end
    end

    always_comb
    begin
        grp_next       = grp_reg;
        grp_valid_next = grp_valid_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (load)
        begin
            out_valid_next     = 1'b1;
            out_next.out_char  = code;
            out_next.last_char = grp_reg.last && (idx_reg == 2'd3);
            idx_next           = idx_reg + 2'd1;
            if (idx_reg == 2'd3)
            begin
                grp_valid_next = 1'b0;
            end
        end

        if (pop_valid && pop_ready)
        begin
            grp_next       = pop_data;
            grp_valid_next = 1'b1;
            idx_next       = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            grp_valid_reg <= grp_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        grp_reg <= grp_next;
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_idx_needs_group: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg != 2'd0) |-> grp_valid_reg)
        else $error("character index advanced with no group held");

    a_group_start: assert property (@(posedge clk) disable iff (!rst_n)
        (pop_valid && pop_ready) |=> (grp_valid_reg && idx_reg == 2'd0))
        else $error("fetched group did not start at its first character");

endmodule

`default_nettype wire

[design/base64_encoder.sv]
// ---------------------------------------------------------------------------
// base64_encoder: padded base64 encoder, one byte in, one character out
// Input channel (in_valid/in_ready/in_data) carries one message byte per
// beat with an end-of-message flag. Output channel (out_valid/out_ready/
// out_data) carries one ASCII character per beat; last_char marks the
// final character of a message.
// Every third byte, or a byte flagged as end of message, closes a group
// that produces four characters, padded with '=' for a short group.
// With the output side idle, the edge that accepts a closing beat writes
// its group into the queue; the serialiser then loads the group, and its
// output register raises out_valid with the first character. Output: one
// character per cycle while out_ready is high and groups are queued;
// input: one byte per cycle until the two-group queue is full.
// Reset clears the held byte count, the queue and the output stage; no
// character is pending afterwards.
// When the receiver stalls, the output register holds its beat, the queue
// fills, and in_ready falls once it has no room for another group.
// ---------------------------------------------------------------------------
`default_nettype none

module base64_encoder (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  b64_pkg::in_beat_t      in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output b64_pkg::out_beat_t     out_data
);
    import b64_pkg::*;

    logic   push_valid, push_ready;
    group_t push_data;
    logic   pop_valid, pop_ready;
    group_t pop_data;

    b64_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    b64_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    b64_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule

`default_nettype wire

[test/base64_checker.sv]
// ---------------------------------------------------------------------------
// base64_checker: scoreboard for the base64 encoder
// Watches both channels of the encoder. Every accepted input beat is run
// through a behavioural encoder that queues the characters it should cause;
// every accepted output beat is compared field by field with the oldest
// queued character. Mismatches and unexpected characters are counted.
// ---------------------------------------------------------------------------
`default_nettype none

module base64_checker (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire logic           in_ready,
    input  b64_pkg::in_beat_t   in_data,
    input  wire logic           out_valid,
    input  wire logic           out_ready,
    input  b64_pkg::out_beat_t  out_data,
    output int                  error_count,
    output int                  chars_outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    import b64_pkg::*;

    localparam logic [511:0] ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    logic [7:0]  held_bytes [0:1];
    logic [1:0]  held_count;
    out_beat_t   expected_chars [$];
    out_beat_t   want;

    function automatic logic [6:0] alphabet_char(input logic [5:0] sextet);
        logic [7:0] code;
        code = ALPHABET[8 * (63 - int'(sextet)) +: 8];
        return code[6:0];
    endfunction

    task automatic append_char(input out_beat_t beat);
        expected_chars.insert(expected_chars.size(), beat);
    endtask

    // Missing bytes of a short group arrive here as zero, which gives the
    // zero-filled bits that the standard asks for.
    task automatic queue_group(input logic [7:0] b0, input logic [7:0] b1,
                               input logic [7:0] b2, input logic [1:0] nbytes,
                               input logic last);
        logic [23:0] bits;
        out_beat_t   beat;
        bits = {b0, b1, b2};
        beat.last_char = 1'b0;
        beat.out_char = alphabet_char(bits[23:18]);
        append_char(beat);
        beat.out_char = alphabet_char(bits[17:12]);
        append_char(beat);
        beat.out_char = (nbytes == GRP_ONE) ? PAD_CHAR : alphabet_char(bits[11:6]);
        append_char(beat);
        beat.out_char = (nbytes != GRP_FULL) ? PAD_CHAR : alphabet_char(bits[5:0]);
        beat.last_char = last;
        append_char(beat);
    endtask

    task automatic encode_byte(input in_beat_t beat);
        case (held_count)
            2'd0:
            begin
                if (beat.end_of_message)
                begin
                    queue_group(beat.data_byte, 8'd0, 8'd0, GRP_ONE, 1'b1);
                end
                else
                begin
                    held_bytes[0] = beat.data_byte;
                    held_count = GRP_ONE;
                end
            end
            GRP_ONE:
            begin
                if (beat.end_of_message)
                begin
                    queue_group(held_bytes[0], beat.data_byte, 8'd0, GRP_TWO, 1'b1);
                    held_count = 2'd0;
                end
                else
                begin
                    held_bytes[1] = beat.data_byte;
                    held_count = GRP_TWO;
                end
            end
            default:
            begin
                queue_group(held_bytes[0], held_bytes[1], beat.data_byte, GRP_FULL,
                            beat.end_of_message);
                held_count = 2'd0;
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count = 2'd0;
            expected_chars.delete();
            error_count = 0;
            chars_outstanding <= 0;
        end
        else
        begin
            // The encoder registers each group before its characters leave, so a
            // character can never leave on the same edge as the byte that causes it.
            if (in_valid && in_ready)
            begin
                encode_byte(in_data);
            end
            if (out_valid && out_ready)
            begin
                if (expected_chars.size() == 0)
                begin
                    $display("%0t: unexpected character: got char %h last %b",
                             $time, out_data.out_char, out_data.last_char);
                    error_count++;
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (out_data.out_char !== want.out_char)
                    begin
                        $display("%0t: out_char mismatch: expected %h got %h",
                                 $time, want.out_char, out_data.out_char);
                        error_count++;
                    end
                    if (out_data.last_char !== want.last_char)
                    begin
                        $display("%0t: last_char mismatch: expected %b got %b",
                                 $time, want.last_char, out_data.last_char);
                        error_count++;
                    end
                end
            end
            chars_outstanding <= expected_chars.size();
        end
    end

endmodule

`default_nettype wire

[test/tb_base64_encoder.sv]
// ---------------------------------------------------------------------------
// tb_base64_encoder: testbench for the padded base64 encoder
// Sends a few hand-picked messages covering short and full groups and the
// byte extremes, then random messages in three phases with different
// amounts of idling on each side. A checker beside the encoder predicts
// and compares every character; this module makes stimulus and reports.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_base64_encoder;

    timeunit 1ns;
    timeprecision 1ps;

    import b64_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;

    // Each entry is {end_of_message, data_byte}.
    localparam logic [8:0] DIRECTED [0:20] = '{
        9'h100,
        9'h1FF,
        9'h000, 9'h100,
        9'h0FF, 9'h1FF,
        9'h04D, 9'h061, 9'h16E,
        9'h0FF, 9'h0FF, 9'h0FF, 9'h000, 9'h000, 9'h000, 9'h1FB,
        9'h0FB, 9'h0FF, 9'h0BF, 9'h0AA, 9'h155
    };

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_beat_t  in_data;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_beat_t out_data;

    int        error_count;
    int        chars_outstanding;
    int        tx_idle_pct;
    int        rx_idle_pct = 0;
    int        items_sent;
    int        quiet_cycles;

    always #4 clk = ~clk;

    base64_encoder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    base64_checker u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .in_data           (in_data),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .out_data          (out_data),
        .error_count       (error_count),
        .chars_outstanding (chars_outstanding)
    );

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_base64_encoder failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Leaves valid high after the beat is taken; a pause in the next call
    // or wait_for_drain lowers it, so it never drops and rises on the same edge.
    task automatic send_beat(input logic [7:0] data_byte, input logic eom);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{data_byte: data_byte, end_of_message: eom};
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    task automatic wait_for_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (chars_outstanding != 0)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        int         msg_len;
        int         target;
        logic [7:0] data_byte;

        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        items_sent = 0;
        tx_idle_pct = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        rx_idle_pct = 50;
        for (int i = 0; i < 21; i++)
        begin
            send_beat(DIRECTED[i][7:0], DIRECTED[i][8]);
        end
        wait_for_drain();

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    tx_idle_pct = 33;
                    rx_idle_pct = 87;
                end
                1:
                begin
                    tx_idle_pct = 87;
                    rx_idle_pct = 33;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            target = items_sent + 97;
            while (items_sent < target)
            begin
                // Mostly short messages, so that every group ending is hit
                // often; now and then a longer one.
                msg_len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30)
                                                      : $urandom_range(1, 9);
                for (int k = 0; k < msg_len; k++)
                begin
                    if ($urandom_range(0, 7) == 0)
                    begin
                        data_byte = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                    end
                    else
                    begin
                        data_byte = 8'($urandom_range(0, 255));
                    end
                    send_beat(data_byte, k == msg_len - 1);
                end
            end
            wait_for_drain();
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        if (error_count == 0)
        begin
            $display("tb_base64_encoder passed");
        end
        else
        begin
            $display("tb_base64_encoder failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
